/* design/sht_pkg.sv */
// sht_pkg: shared types and constants for the score hysteresis trigger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

  localparam int TimeBits   = 32;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 16;

  localparam logic [CfgIdxBits-1:0] RegHighThr  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegLowThr   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegHighHold = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegLowHold  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegCooldown = 3'd4;

  localparam logic signed [15:0] HighThrReset = 16'sd3277;
  localparam logic signed [15:0] LowThrReset  = 16'sd819;

  typedef struct packed {
    logic signed [15:0] score;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic fire;
    logic is_active;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] hi_level;
    logic signed [15:0] lo_level;
    logic [15:0]        hi_hold;
    logic [15:0]        lo_hold;
    logic [15:0]        refire_gap;
  } cfg_t;

  typedef struct packed {
    logic [TimeBits-1:0] high_start;
    logic [TimeBits-1:0] low_start;
    logic [TimeBits-1:0] last_fire;
    logic                active;
  } trig_state_t;

endpackage

`default_nettype wire

/* design/sht_cfg.sv */
// sht_cfg: configuration register file (thresholds, hold times, cooldown).
// Depends on sht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sht_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sht_pkg::CfgIdxBits-1:0] cfg_addr_i,
  input  wire logic [sht_pkg::CfgBits-1:0]    cfg_wdata_i,
  output sht_pkg::cfg_t                       cfg_o
);
  import sht_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegHighThr:  cfg_d.hi_level   = cfg_wdata_i;
        RegLowThr:   cfg_d.lo_level   = cfg_wdata_i;
        RegHighHold: cfg_d.hi_hold    = cfg_wdata_i;
        RegLowHold:  cfg_d.lo_hold    = cfg_wdata_i;
        RegCooldown: cfg_d.refire_gap = cfg_wdata_i;
        default:     cfg_d = cfg_q;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hi_level   <= HighThrReset;
      cfg_q.lo_level   <= LowThrReset;
      cfg_q.hi_hold    <= '0;
      cfg_q.lo_hold    <= '0;
      cfg_q.refire_gap <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/sht_core.sv */
// sht_core: combinational trigger update for one beat: next state and result.
// Depends on sht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sht_core (
  input  wire sht_pkg::cfg_t        cfg_i,
  input  wire sht_pkg::trig_state_t state_i,
  input  wire sht_pkg::in_item_t    item_i,
  output sht_pkg::trig_state_t      state_o,
  output sht_pkg::out_item_t        res_o
);
  import sht_pkg::*;

  logic [TimeBits-1:0] now;
  logic [TimeBits-1:0] high_mark;
  logic [TimeBits-1:0] low_mark;
  logic [TimeBits-1:0] high_elapsed;
  logic [TimeBits-1:0] low_elapsed;
  logic [TimeBits-1:0] fire_elapsed;
  logic                is_high;
  logic                is_low;
  logic                activate;
  logic                cool_ok;

  assign now = TimeBits'(item_i.time_ms);

  // high wins when the thresholds overlap
  assign is_high = item_i.score >= cfg_i.hi_level;
  assign is_low  = !is_high && (item_i.score <= cfg_i.lo_level);

  // a zero mark means unset; it is taken from the current time
  assign high_mark = (state_i.high_start == '0) ? now : state_i.high_start;
  assign low_mark  = (state_i.low_start == '0) ? now : state_i.low_start;

  assign high_elapsed = now - high_mark;
  assign low_elapsed  = now - low_mark;
  assign fire_elapsed = now - state_i.last_fire;

  assign activate = is_high && !state_i.active &&
                    (high_elapsed >= TimeBits'(cfg_i.hi_hold));
  assign cool_ok  = fire_elapsed >= TimeBits'(cfg_i.refire_gap);

  always_comb begin
    state_o = state_i;
    if (is_high) begin
      state_o.high_start = high_mark;
      state_o.low_start  = '0;
      if (activate) begin
        state_o.active = 1'b1;
        if (cool_ok) begin
          state_o.last_fire = now;
        end
      end
    end else if (is_low) begin
      state_o.low_start  = low_mark;
      state_o.high_start = '0;
      if (state_i.active && (low_elapsed >= TimeBits'(cfg_i.lo_hold))) begin
        state_o.active = 1'b0;
      end
    end
  end

  assign res_o.fire      = activate && cool_ok;
  assign res_o.is_active = state_o.active;

endmodule

`default_nettype wire

/* design/score_hysteresis_trigger.sv */
// score_hysteresis_trigger: hysteresis trigger channel with hold and cooldown.
// Stages: input register, then result register; the state update is combinational.
// Throughput: one beat per cycle while the output is not stalled.
// Reset (async, active low): stages empty, time marks and last firing time zero,
// channel inactive, registers at their reset values.
// Depends on sht_pkg, sht_cfg, sht_core.
`timescale 1ns / 1ps
`default_nettype none

module score_hysteresis_trigger (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sht_pkg::CfgIdxBits-1:0] cfg_addr_i,
  input  wire logic [sht_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire sht_pkg::in_item_t              in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output sht_pkg::out_item_t                  out_o
);
  import sht_pkg::*;

  cfg_t        cfg;
  trig_state_t state_q, state_d;
  in_item_t    item_q;
  logic        item_valid_q;
  out_item_t   res_d, res_q;
  logic        res_valid_q;
  logic        advance;

  sht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sht_core u_core (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // the held beat moves to the result register when that one is free
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

  // a fire beat always reports the channel active
  a_fire_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.fire |-> out_o.is_active)
    else $error("fire without active flag");

  // firing only happens on activation from the inactive state
  a_fire_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.fire |-> !state_q.active)
    else $error("fire while already active");

  // trigger state only moves when a beat is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a beat");

  // taking a beat while the input stage is full requires it to drain
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && item_valid_q |-> advance)
    else $error("input stage overwritten");

endmodule

`default_nettype wire
